// ===== hdl/tnt_pkg.sv =====
`default_nettype none
package tnt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OCT,
    ST_ISSUE,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic       write;
    logic       load_query;
    logic       oct_setup;
    logic       issue;
    logic [2:0] corner;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic last_octave;
    logic busy;
    logic out_free;
  } sts_t;

  localparam int CW = 5;
  localparam int NVW = 16;
  localparam int WW = 8;
  localparam int ACCW = 64;
  localparam logic [2:0] LAST_CORNER = 3'd7;

  function automatic logic [15:0] sine_quarter(input logic [5:0] idx);
    logic [15:0] v;
    case (idx)
      6'd0: v = 16'd0;      6'd1: v = 16'd1608;   6'd2: v = 16'd3212;
      6'd3: v = 16'd4808;   6'd4: v = 16'd6393;   6'd5: v = 16'd7962;
      6'd6: v = 16'd9512;   6'd7: v = 16'd11039;  6'd8: v = 16'd12540;
      6'd9: v = 16'd14010;  6'd10: v = 16'd15447; 6'd11: v = 16'd16846;
      6'd12: v = 16'd18205; 6'd13: v = 16'd19520; 6'd14: v = 16'd20788;
      6'd15: v = 16'd22006; 6'd16: v = 16'd23170; 6'd17: v = 16'd24279;
      6'd18: v = 16'd25330; 6'd19: v = 16'd26320; 6'd20: v = 16'd27246;
      6'd21: v = 16'd28106; 6'd22: v = 16'd28899; 6'd23: v = 16'd29622;
      6'd24: v = 16'd30274; 6'd25: v = 16'd30853; 6'd26: v = 16'd31357;
      6'd27: v = 16'd31786; 6'd28: v = 16'd32138; 6'd29: v = 16'd32413;
      6'd30: v = 16'd32610; 6'd31: v = 16'd32729; 6'd32: v = 16'd32768;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Ripple in Q2.15: 32768 plus or minus the quarter-wave value.
  function automatic logic [16:0] ripple(input logic [4:0] x, input logic [4:0] y,
                                         input logic [4:0] z);
    logic [6:0] p;
    logic [16:0] r;
    p = 7'(7'(x) + 7'(z) - {y, 2'b00});
    if (p <= 7'd32) begin
      r = 17'd32768 + 17'(sine_quarter(p[5:0]));
    end else if (p <= 7'd64) begin
      r = 17'd32768 + 17'(sine_quarter(6'(7'd64 - p)));
    end else if (p <= 7'd96) begin
      r = 17'd32768 - 17'(sine_quarter(6'(p - 7'd64)));
    end else begin
      r = 17'd32768 - 17'(sine_quarter(6'(8'd128 - 8'(p))));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/turbulence_noise_texel_top.sv =====
// Channel | Dir | Fields (lowest bit first)
// s_*     | in  | tdata: coord_x, coord_y, coord_z, noise_value; tuser: opcode
// m_*     | out | tdata: texel; tuser: saturated
// cfg_*   | in  | data: max_zoom_log2
// A lattice write gives no result.
// A query gives one result; for each of max_zoom_log2+1 octaves it runs a setup step and
// eight lattice reads through the single memory port, then drains the read pipeline and
// finishes, after which the next request is taken.
// Reset (rst, synchronous) clears control state; the lattice is not cleared.
// A finished result waits in the output register; the next request is accepted meanwhile.
// A query that finishes while the previous result still waits holds until it is taken.
`default_nettype none
module turbulence_noise_texel_top #(
  parameter int SIDE = 32,
  parameter int NOISE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // coord_x, coord_y, coord_z, noise_value
  input  wire logic        s_tuser,   // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // texel
  output logic             m_tuser,   // saturated
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data
);

  tnt_pkg::cmd_t cmd;
  tnt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .opcode   (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tnt_datapath #(
    .SIDE       (SIDE),
    .NOISE_BITS (NOISE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

// ===== hdl/tnt_ctrl.sv =====
`default_nettype none
module tnt_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        opcode,
  output logic             s_tready,
  output tnt_pkg::cmd_t    cmd,
  input  tnt_pkg::sts_t    sts
);

  tnt_pkg::state_t state, state_next;
  logic [2:0] corner, corner_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tnt_pkg::ST_IDLE;
      corner <= '0;
    end else begin
      state <= state_next;
      corner <= corner_next;
    end
  end

  always_comb begin
    state_next = state;
    corner_next = corner;
    case (state)
      tnt_pkg::ST_IDLE: begin
        if (s_tvalid && opcode) begin
          state_next = tnt_pkg::ST_OCT;
        end
      end
      tnt_pkg::ST_OCT: begin
        state_next = tnt_pkg::ST_ISSUE;
        corner_next = '0;
      end
      tnt_pkg::ST_ISSUE: begin
        corner_next = corner + 3'd1;
        if (corner == tnt_pkg::LAST_CORNER) begin
          state_next = sts.last_octave ? tnt_pkg::ST_DRAIN : tnt_pkg::ST_OCT;
        end
      end
      tnt_pkg::ST_DRAIN: begin
        if (!sts.busy) begin
          state_next = tnt_pkg::ST_FIN;
        end
      end
      tnt_pkg::ST_FIN: begin
        if (sts.out_free) begin
          state_next = tnt_pkg::ST_IDLE;
        end
      end
      default: state_next = tnt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == tnt_pkg::ST_IDLE);
    cmd.write = (state == tnt_pkg::ST_IDLE) && s_tvalid && !opcode;
    cmd.load_query = (state == tnt_pkg::ST_IDLE) && s_tvalid && opcode;
    cmd.oct_setup = (state == tnt_pkg::ST_OCT);
    cmd.issue = (state == tnt_pkg::ST_ISSUE);
    cmd.corner = corner;
    cmd.finish = (state == tnt_pkg::ST_FIN) && sts.out_free;
  end

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.busy) else $error("finish with corners in flight");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !sts.busy) else $error("idle with corners in flight");
  a_query_setup: assert property (@(posedge clk) disable iff (rst)
    cmd.load_query |=> state == tnt_pkg::ST_OCT) else $error("query did not start");
  a_last_drain: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.corner == tnt_pkg::LAST_CORNER && sts.last_octave)
    |=> state == tnt_pkg::ST_DRAIN) else $error("last octave did not drain");

endmodule
`default_nettype wire

// ===== hdl/tnt_datapath.sv =====
`default_nettype none
module tnt_datapath #(
  parameter int SIDE = 32,
  parameter int NOISE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] s_tdata,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_data,
  input  tnt_pkg::cmd_t    cmd,
  output tnt_pkg::sts_t    sts,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tuser
);

  localparam int DEPTH = SIDE * SIDE * SIDE;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = (SIDE > 2) ? $clog2(SIDE) : 1;
  localparam int PW = 3 * tnt_pkg::WW + NOISE_BITS;
  localparam logic [9:0] SIDE_M1 = 10'(SIDE - 1);

  function automatic logic [IW-1:0] clamp_side(input logic [9:0] v);
    return (v > SIDE_M1) ? IW'(SIDE_M1) : IW'(v);
  endfunction

  logic [4:0] in_x, in_y, in_z;
  logic [15:0] in_nv;
  assign in_x = s_tdata[4:0];
  assign in_y = s_tdata[9:5];
  assign in_z = s_tdata[14:10];
  assign in_nv = s_tdata[30:15];

  logic [2:0] max_zoom_log2, lvl, k;
  logic [4:0] cx, cy, cz;
  logic [IW-1:0] hi [3];
  logic [IW-1:0] lo [3];
  logic [7:0] fr [3];
  logic [7:0] zoom;
  logic [tnt_pkg::ACCW-1:0] acc;

  logic [NOISE_BITS-1:0] mem [DEPTH];
  logic [NOISE_BITS-1:0] wdata, rdata;
  logic [AW-1:0] waddr, raddr, addr;
  logic wr_ok;

  always_comb begin
    for (int b = 0; b < NOISE_BITS; b++) begin
      wdata[b] = (b < tnt_pkg::NVW) ? in_nv[b % tnt_pkg::NVW] : 1'b0;
    end
  end

  assign wr_ok = (9'(in_x) < 9'(SIDE)) && (9'(in_y) < 9'(SIDE)) && (9'(in_z) < 9'(SIDE));
  assign waddr = AW'((AW'(in_x) * AW'(SIDE) + AW'(in_y)) * AW'(SIDE) + AW'(in_z));

  // Octave setup: cell index, fraction and lower neighbor per axis.
  logic [4:0] cin [3];
  logic [IW-1:0] hi_n [3];
  logic [IW-1:0] lo_n [3];
  logic [7:0] fr_n [3];
  logic [7:0] zoom_n;
  logic [9:0] size_n, wrap_n;

  always_comb begin
    logic [4:0] i;
    cin[0] = cx;
    cin[1] = cy;
    cin[2] = cz;
    zoom_n = 8'd1 << k;
    size_n = (k == 3'd0) ? 10'(SIDE) : ((10'(SIDE) + (10'd1 << (k - 3'd1))) >> k);
    wrap_n = (size_n != 10'd0) ? size_n - 10'd1 : 10'd0;
    for (int a = 0; a < 3; a++) begin
      i = cin[a] >> k;
      fr_n[a] = 8'(cin[a]) & (zoom_n - 8'd1);
      hi_n[a] = clamp_side(10'(i));
      lo_n[a] = (i != 5'd0) ? clamp_side(10'(i) - 10'd1) : clamp_side(wrap_n);
    end
  end

  // Corner selection.
  logic [IW-1:0] ix, iy, iz;
  logic [7:0] wx, wy, wz;
  logic [4:0] sh_n;
  always_comb begin
    ix = cmd.corner[0] ? hi[0] : lo[0];
    iy = cmd.corner[1] ? hi[1] : lo[1];
    iz = cmd.corner[2] ? hi[2] : lo[2];
    wx = cmd.corner[0] ? fr[0] : zoom - fr[0];
    wy = cmd.corner[1] ? fr[1] : zoom - fr[1];
    wz = cmd.corner[2] ? fr[2] : zoom - fr[2];
    sh_n = 5'({4'(lvl - k), 1'b0}) + 5'd12;
  end
  assign raddr = AW'((AW'(ix) * AW'(SIDE) + AW'(iy)) * AW'(SIDE) + AW'(iz));
  assign addr = cmd.write ? waddr : raddr;

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  logic v1, v2, v3;
  logic [15:0] wxy1;
  logic [7:0] wz1;
  logic [4:0] sh1, sh2, sh3;
  logic [23:0] w2;
  logic [NOISE_BITS-1:0] d2;
  logic [PW-1:0] p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      max_zoom_log2 <= 3'd5;
      m_tvalid <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      if (cfg_valid) begin
        max_zoom_log2 <= cfg_data;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wxy1 <= wx * wy;
    wz1 <= wz;
    sh1 <= sh_n;
    w2 <= 24'(wxy1) * 24'(wz1);
    d2 <= rdata;
    sh2 <= sh1;
    p3 <= PW'(w2) * PW'(d2);
    sh3 <= sh2;
    if (cmd.load_query) begin
      cx <= in_x;
      cy <= in_y;
      cz <= in_z;
      lvl <= max_zoom_log2;
      k <= max_zoom_log2;
      acc <= tnt_pkg::ACCW'(tnt_pkg::ripple(in_x, in_y, in_z))
             << (6'({max_zoom_log2, 1'b0}) + 6'(NOISE_BITS));
    end else begin
      if (v3) begin
        acc <= acc + (tnt_pkg::ACCW'(p3) << sh3);
      end
      if (cmd.issue && cmd.corner == tnt_pkg::LAST_CORNER && k != 3'd0) begin
        k <= k - 3'd1;
      end
    end
    if (cmd.oct_setup) begin
      hi <= hi_n;
      lo <= lo_n;
      fr <= fr_n;
      zoom <= zoom_n;
    end
  end

  logic [tnt_pkg::ACCW-1:0] res;
  assign res = acc >> (6'(lvl) * 6'd3 + 6'(NOISE_BITS) + 6'd5);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tuser <= (res[tnt_pkg::ACCW-1:8] != '0);
      m_tdata <= (res[tnt_pkg::ACCW-1:8] != '0) ? 8'hFF : res[7:0];
    end
  end

  assign sts.last_octave = (k == 3'd0);
  assign sts.busy = v1 | v2 | v3;
  assign sts.out_free = !m_tvalid || m_tready;

endmodule
`default_nettype wire
